FILE: rtl/core/ipid_pkg.sv
// Shared widths, types and register indexes for the incremental PID controller.
// Used by incremental_pid_controller and its port checker; depends on nothing.
`default_nettype none

package ipid_pkg;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W - 16;  // gain*error after the Q16.16 shift
    localparam int ACC_W      = PROD_W + 2;       // room for three products and the drive
    localparam int CFG_ADDR_W = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [2*DATA_W-1:0] full_prod_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_TARGET     = 3'd0;
    localparam cfg_addr_t REG_GAIN_CUR   = 3'd1;
    localparam cfg_addr_t REG_GAIN_PREV  = 3'd2;
    localparam cfg_addr_t REG_GAIN_OLDER = 3'd3;
    localparam cfg_addr_t REG_UPPER      = 3'd4;
    localparam cfg_addr_t REG_LOWER      = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/core/incremental_pid_controller.sv
// Velocity-form PID controller: measurement stream in, clamped drive stream out.
// Depends on ipid_pkg for widths, types and register indexes.
//
// One drive sample is produced for every measurement sample, and a new sample is
// taken on every clock while the output side keeps up: one item per cycle. The
// pipeline is input register, error subtract and saturate, four parallel 32x32
// products, product sums, and a last stage that adds the held drive, clamps to
// upper_limit then lower_limit and holds the result; that last stage is the only
// one fed back on itself, which is what allows one sample per cycle. A stall on
// m_tready freezes the whole pipeline. Gains, setpoint and limits are written
// through cfg_wr_en/cfg_addr/cfg_wdata; the user must write them only while no
// sample is in flight, as the block does not enforce it. Unknown indexes are
// ignored. All values are signed Q16.16.
`default_nettype none

module incremental_pid_controller (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration writes
    input  wire logic                         cfg_wr_en,
    input  wire ipid_pkg::cfg_addr_t          cfg_addr,
    input  wire logic [ipid_pkg::DATA_W-1:0]  cfg_wdata,
    // measurement requests
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    input  wire logic [ipid_pkg::DATA_W-1:0]  s_tdata,   // [31:0] measured
    // drive results
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    output      logic [ipid_pkg::DATA_W-1:0]  m_tdata    // [31:0] drive
);

    // configuration
    ipid_pkg::data_t target_reg, gain_cur_reg, gain_prev_reg, gain_older_reg;
    ipid_pkg::data_t upper_reg, lower_reg;

    // pipeline
    logic            advance;
    logic            in_vld_reg, err_vld_reg, prod_vld_reg, sum_vld_reg, out_vld_reg;
    ipid_pkg::data_t meas_reg;
    ipid_pkg::data_t err_reg, err_next;
    ipid_pkg::data_t prev_err_reg, older_err_reg;
    ipid_pkg::prod_t p_cur_reg, p_prev_reg, p_older_reg, p_sat_reg;
    ipid_pkg::acc_t  sum_full_reg, sum_sat_reg;
    ipid_pkg::data_t drive_reg, drive_next;

    logic signed [ipid_pkg::DATA_W:0] diff;
    ipid_pkg::full_prod_t             m_cur, m_prev, m_older, m_sat;
    ipid_pkg::acc_t                   drive_ext, upper_ext, lower_ext;
    ipid_pkg::acc_t                   acc_full, acc_sat, acc_sel, acc_hi, acc_lo;
    logic                             sat;

    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = drive_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= '0;
            gain_cur_reg   <= '0;
            gain_prev_reg  <= '0;
            gain_older_reg <= '0;
            upper_reg      <= '0;
            lower_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ipid_pkg::REG_TARGET:     target_reg     <= cfg_wdata;
                ipid_pkg::REG_GAIN_CUR:   gain_cur_reg   <= cfg_wdata;
                ipid_pkg::REG_GAIN_PREV:  gain_prev_reg  <= cfg_wdata;
                ipid_pkg::REG_GAIN_OLDER: gain_older_reg <= cfg_wdata;
                ipid_pkg::REG_UPPER:      upper_reg      <= cfg_wdata;
                ipid_pkg::REG_LOWER:      lower_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // error, saturated to the data range
    always_comb begin
        diff = {target_reg[ipid_pkg::DATA_W-1], target_reg}
             - {meas_reg[ipid_pkg::DATA_W-1], meas_reg};
        if (diff[ipid_pkg::DATA_W] != diff[ipid_pkg::DATA_W-1]) begin
            err_next = diff[ipid_pkg::DATA_W]
                     ? {1'b1, {(ipid_pkg::DATA_W-1){1'b0}}}
                     : {1'b0, {(ipid_pkg::DATA_W-1){1'b1}}};
        end else begin
            err_next = diff[ipid_pkg::DATA_W-1:0];
        end
    end

    // exact products; dropping the low 16 bits floors toward minus infinity
    assign m_cur   = ipid_pkg::full_prod_t'(gain_cur_reg)   * ipid_pkg::full_prod_t'(err_reg);
    assign m_prev  = ipid_pkg::full_prod_t'(gain_prev_reg)  * ipid_pkg::full_prod_t'(prev_err_reg);
    assign m_older = ipid_pkg::full_prod_t'(gain_older_reg) * ipid_pkg::full_prod_t'(older_err_reg);
    assign m_sat   = ipid_pkg::full_prod_t'(gain_prev_reg)  * ipid_pkg::full_prod_t'(older_err_reg);

    // recurrence: held drive plus the product sum picked by the saturation test
    always_comb begin
        drive_ext = ipid_pkg::acc_t'(drive_reg);
        upper_ext = ipid_pkg::acc_t'(upper_reg);
        lower_ext = ipid_pkg::acc_t'(lower_reg);
        sat       = (drive_reg >= upper_reg) || (drive_reg <= lower_reg);
        acc_full  = drive_ext + sum_full_reg;
        acc_sat   = drive_ext + sum_sat_reg;
        acc_sel   = sat ? acc_sat : acc_full;
        acc_hi    = (acc_sel > upper_ext) ? upper_ext : acc_sel;
        acc_lo    = (acc_hi < lower_ext) ? lower_ext : acc_hi;
        drive_next = acc_lo[ipid_pkg::DATA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            err_vld_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            sum_vld_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
            prev_err_reg  <= '0;
            older_err_reg <= '0;
            drive_reg     <= '0;
        end else if (advance) begin
            in_vld_reg   <= s_tvalid;
            err_vld_reg  <= in_vld_reg;
            prod_vld_reg <= err_vld_reg;
            sum_vld_reg  <= prod_vld_reg;
            out_vld_reg  <= sum_vld_reg;
            // shift the error history as each sample reaches the products
            if (err_vld_reg) begin
                prev_err_reg  <= err_reg;
                older_err_reg <= prev_err_reg;
            end
            if (sum_vld_reg) begin
                drive_reg <= drive_next;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge aclk) begin
        if (advance) begin
            meas_reg     <= s_tdata;
            err_reg      <= err_next;
            p_cur_reg    <= m_cur[2*ipid_pkg::DATA_W-1:16];
            p_prev_reg   <= m_prev[2*ipid_pkg::DATA_W-1:16];
            p_older_reg  <= m_older[2*ipid_pkg::DATA_W-1:16];
            p_sat_reg    <= m_sat[2*ipid_pkg::DATA_W-1:16];
            sum_full_reg <= ipid_pkg::acc_t'(p_cur_reg) + ipid_pkg::acc_t'(p_prev_reg)
                          + ipid_pkg::acc_t'(p_older_reg);
            sum_sat_reg  <= ipid_pkg::acc_t'(p_cur_reg) + ipid_pkg::acc_t'(p_sat_reg);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ipid_checker.sv
// Port-level checks for incremental_pid_controller, and the bind that attaches them.
// Depends on ipid_pkg for the data width; sees only the top level's ports.
`default_nettype none

module ipid_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [ipid_pkg::DATA_W-1:0] m_tdata
);

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("drive changed or dropped while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // with the output register empty the block must take requests
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !m_tvalid |-> s_tready)
        else $error("request refused with empty output");

endmodule

bind incremental_pid_controller ipid_checker u_ipid_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/tb.sv
// Testbench for incremental_pid_controller: streams measurement samples, predicts every
// drive sample with its own Q16.16 velocity-form model and compares results in order.
// Depends on ipid_pkg and the incremental_pid_controller RTL only.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // indexes above the register file; writes there must leave the block untouched
    localparam ipid_pkg::cfg_addr_t REG_SPARE_LO = 3'd6;
    localparam ipid_pkg::cfg_addr_t REG_SPARE_HI = 3'd7;

    localparam longint ERR_MAX       = 64'sd2147483647;
    localparam longint ERR_MIN       = -64'sd2147483648;
    localparam int     SETTLE_CYCLES = 10;
    localparam int     RANDOM_ITEMS  = 725;
    // slowest run: roughly 750 samples, with gaps between bursts and a settle per phase
    localparam int     CYCLE_LIMIT   = 400000;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_SPARSE} rx_mode_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    ipid_pkg::cfg_addr_t             cfg_addr  = '0;
    logic [ipid_pkg::DATA_W-1:0]     cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [ipid_pkg::DATA_W-1:0]     s_tdata   = '0;   // [31:0] measured
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [ipid_pkg::DATA_W-1:0]     m_tdata;          // [31:0] drive

    incremental_pid_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10ns aclk = 1'b1;
        #10ns aclk = 1'b0;
    end

    // controller settings and loop state as the testbench sees them
    ipid_pkg::data_t sp_target  = '0;
    ipid_pkg::data_t gain_cur   = '0;
    ipid_pkg::data_t gain_prev  = '0;
    ipid_pkg::data_t gain_older = '0;
    ipid_pkg::data_t limit_hi   = '0;
    ipid_pkg::data_t limit_lo   = '0;
    ipid_pkg::data_t last_drive = '0;
    ipid_pkg::data_t err_n1     = '0;
    ipid_pkg::data_t err_n2     = '0;

    ipid_pkg::data_t drive_q[$];
    ipid_pkg::data_t due_drive;
    int    fault_count  = 0;
    int    result_count = 0;
    int    cycle_count  = 0;
    int    burst_left   = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    // exact Q32.32 product, floored back to Q16.16
    function automatic longint q16_product(ipid_pkg::data_t gain, ipid_pkg::data_t err);
        longint p;
        p = longint'(gain) * longint'(err);
        return p >>> 16;
    endfunction

    function automatic ipid_pkg::data_t next_drive(ipid_pkg::data_t meas);
        longint err;
        longint acc;
        logic   held;
        err = longint'(sp_target) - longint'(meas);
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < ERR_MIN) err = ERR_MIN;
        held = (last_drive >= limit_hi) || (last_drive <= limit_lo);
        acc = longint'(last_drive) + q16_product(gain_cur, ipid_pkg::data_t'(err));
        // at a limit only the two-back error takes the previous-error gain
        if (held) begin
            acc += q16_product(gain_prev, err_n2);
        end else begin
            acc += q16_product(gain_prev, err_n1) + q16_product(gain_older, err_n2);
        end
        if (acc > longint'(limit_hi)) acc = longint'(limit_hi);
        if (acc < longint'(limit_lo)) acc = longint'(limit_lo);
        last_drive = ipid_pkg::data_t'(acc);
        err_n2 = err_n1;
        err_n1 = ipid_pkg::data_t'(err);
        return last_drive;
    endfunction

    function automatic ipid_pkg::data_t extreme_value();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h0001_0000;
            default: return 32'hffff_0000;
        endcase
    endfunction

    // +/- 4.0 in Q16.16
    function automatic ipid_pkg::data_t small_gain();
        return ipid_pkg::data_t'(int'($urandom_range(0, 524288)) - 262144);
    endfunction

    // enter and leave at a falling edge
    task automatic write_reg(ipid_pkg::cfg_addr_t idx, ipid_pkg::data_t val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ipid_pkg::REG_TARGET:     sp_target  = val;
            ipid_pkg::REG_GAIN_CUR:   gain_cur   = val;
            ipid_pkg::REG_GAIN_PREV:  gain_prev  = val;
            ipid_pkg::REG_GAIN_OLDER: gain_older = val;
            ipid_pkg::REG_UPPER:      limit_hi   = val;
            ipid_pkg::REG_LOWER:      limit_lo   = val;
            default: ;
        endcase
    endtask

    // drop the request and wait until every drive sample is home
    task automatic settle();
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apply_settings(ipid_pkg::data_t tgt, ipid_pkg::data_t kc,
                                  ipid_pkg::data_t kp, ipid_pkg::data_t ko,
                                  ipid_pkg::data_t hi, ipid_pkg::data_t lo);
        settle();
        write_reg(ipid_pkg::REG_TARGET, tgt);
        write_reg(ipid_pkg::REG_GAIN_CUR, kc);
        write_reg(ipid_pkg::REG_GAIN_PREV, kp);
        write_reg(ipid_pkg::REG_GAIN_OLDER, ko);
        write_reg(ipid_pkg::REG_UPPER, hi);
        write_reg(ipid_pkg::REG_LOWER, lo);
    endtask

    // called at a falling edge; the request stays up across a burst
    task automatic send_measure(ipid_pkg::data_t meas);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= meas;
        do @(posedge aclk); while (!s_tready);
        drive_q.push_back(next_drive(meas));
        @(negedge aclk);
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
    endtask

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 120);
        end
        rx_left = rx_left - 1;
        rx_tick = rx_tick + 1;
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RX_QUARTER: m_tready <= (rx_tick % 4 == 0);
            default:    m_tready <= (rx_tick % 13 == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_count = result_count + 1;
            if (drive_q.size() == 0) begin
                fault_count = fault_count + 1;
                if (fault_count <= 10)
                    $display("unexpected drive 0x%08h on result %0d, nothing pending",
                             m_tdata, result_count);
            end else begin
                due_drive = drive_q.pop_front();
                if (m_tdata !== due_drive) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= 10)
                        $display({"drive mismatch on result %0d: ",
                                  "expected 0x%08h (%0d), got 0x%08h (%0d)"},
                                 result_count, due_drive, due_drive, m_tdata, $signed(m_tdata));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("incremental_pid_controller regression: fail");
            $finish;
        end
    end

    // limits both zero after reset, so the held formula applies and drive stays 0
    task automatic test_reset_state();
        send_measure(32'h8000_0000);
        send_measure(32'h7fff_ffff);
    endtask

    task automatic test_tracking();
        apply_settings(32'h0005_0000, 32'h0001_8000, 32'hffff_4000, 32'h0000_2000,
                       32'h0064_0000, 32'hff9c_0000);
        send_measure(32'h0000_0000);
        send_measure(32'h0001_0000);
        send_measure(32'h0004_8000);
        send_measure(32'hffff_0000);
        send_measure(32'h0012_3456);
    endtask

    // drive into the upper limit, hold there, then swing into the lower one
    task automatic test_clamp_hold();
        apply_settings(32'h0000_0000, 32'h0004_0000, 32'h0003_0000, 32'hfffe_0000,
                       32'h0002_0000, 32'hfffe_0000);
        send_measure(32'hfff0_0000);
        send_measure(32'h0000_0000);
        send_measure(32'h0010_0000);
        send_measure(32'h0000_8000);
    endtask

    task automatic test_error_saturation();
        apply_settings(32'h7fff_ffff, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                       32'h7fff_ffff, 32'h8000_0000);
        send_measure(32'h8000_0000);
        send_measure(32'hffff_ffff);
        apply_settings(32'h8000_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000,
                       32'h7fff_ffff, 32'h8000_0000);
        send_measure(32'h7fff_ffff);
        send_measure(32'h0000_0001);
    endtask

    // lower above upper: the lower clamp wins every time
    task automatic test_crossed_limits();
        apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                       32'hfff0_0000, 32'h0010_0000);
        send_measure(32'h0000_0000);
        send_measure(32'h7fff_ffff);
        send_measure(32'h8000_0000);
    endtask

    task automatic test_extreme_settings();
        apply_settings(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                       32'h7fff_ffff, 32'h8000_0000);
        send_measure(32'h8000_0000);
        send_measure(32'h7fff_ffff);
        send_measure(32'h8000_0000);
        send_measure(32'h0000_0000);
    endtask

    task automatic test_spare_index();
        settle();
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        repeat (3) send_measure($urandom);
    endtask

    task automatic test_random_operation();
        int              left;
        int              n;
        int              kind;
        ipid_pkg::data_t tgt;
        ipid_pkg::data_t kc;
        ipid_pkg::data_t kp;
        ipid_pkg::data_t ko;
        ipid_pkg::data_t hi;
        ipid_pkg::data_t lo;
        ipid_pkg::data_t meas;
        left = RANDOM_ITEMS;
        while (left > 0) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                // plausible tuning, sometimes with a narrow output band
                tgt = ipid_pkg::data_t'(int'($urandom_range(0, 2097152)) - 1048576);
                kc  = small_gain();
                kp  = small_gain();
                ko  = small_gain();
                hi  = ipid_pkg::data_t'(int'($urandom_range(0, 4194304)) - 524288);
                lo  = hi - ipid_pkg::data_t'(($urandom_range(0, 2) == 0)
                                             ? $urandom_range(1, 65536)
                                             : $urandom_range(65536, 4194304));
            end else if (kind < 8) begin
                tgt = $urandom;
                kc  = $urandom;
                kp  = $urandom;
                ko  = $urandom;
                hi  = $urandom;
                lo  = $urandom;
            end else if (kind == 8) begin
                tgt = extreme_value();
                kc  = extreme_value();
                kp  = extreme_value();
                ko  = extreme_value();
                hi  = extreme_value();
                lo  = extreme_value();
            end else begin
                tgt = ipid_pkg::data_t'(int'($urandom_range(0, 2097152)) - 1048576);
                kc  = small_gain();
                kp  = small_gain();
                ko  = small_gain();
                hi  = ipid_pkg::data_t'(int'($urandom_range(0, 1048576)) - 524288);
                lo  = hi + ipid_pkg::data_t'($urandom_range(1, 1048576));
            end
            apply_settings(tgt, kc, kp, ko, hi, lo);
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            n = $urandom_range(20, 60);
            if (n > left) n = left;
            repeat (n) begin
                kind = $urandom_range(0, 9);
                if (kind < 8)
                    meas = tgt + ipid_pkg::data_t'(int'($urandom_range(0, 524288)) - 262144);
                else if (kind == 8) meas = $urandom;
                else meas = extreme_value();
                send_measure(meas);
            end
            left = left - n;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_tracking();
        test_clamp_hold();
        test_error_saturation();
        test_crossed_limits();
        test_extreme_settings();
        test_spare_index();
        test_random_operation();
        settle();
        if (fault_count == 0) begin
            $display("incremental_pid_controller regression: pass");
        end else begin
            $display("incremental_pid_controller regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/ipid_pkg.sv
rtl/core/incremental_pid_controller.sv
rtl/core/ipid_checker.sv
verif/tb.sv
